// ===== rtl/gisum_pkg.sv =====
`default_nettype none
package gisum_pkg;
  localparam int unsigned CellW = 6;
  localparam int unsigned Cells = 64;
  localparam int unsigned SumW = 10;
  localparam int unsigned Slots = 32;
  localparam int unsigned SlotW = 5;
  localparam int unsigned CntW = 6;

  localparam logic [0:0] CfgRows = 1'b0;
  localparam logic [0:0] CfgCols = 1'b1;

  typedef enum logic [12:0] {
    ST_LOAD   = 13'b0000000000001,
    ST_SCAN   = 13'b0000000000010,
    ST_SEED   = 13'b0000000000100,
    ST_POP    = 13'b0000000001000,
    ST_NBR    = 13'b0000000010000,
    ST_DONE   = 13'b0000000100000,
    ST_SORT   = 13'b0000001000000,
    ST_EMIT   = 13'b0000010000000,
    ST_WAIT   = 13'b0000100000000,
    ST_CLEAR  = 13'b0001000000000,
    ST_INIT   = 13'b0010000000000,
    ST_TAKE   = 13'b0100000000000,
    ST_CHK    = 13'b1000000000000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;      // store one cell weight
    logic       scan_rst;  // scan pointer to zero
    logic       scan_inc;
    logic       scan_rd;   // read the grid word at the scan cell
    logic       seed;      // start a region at the scan cell
    logic       pop;       // read the queue head
    logic       take;      // latch the head coordinates, add its weight
    logic [1:0] dir;       // neighbor under test
    logic       nbr_rd;    // read the grid word of that neighbor
    logic       nbr;       // push that neighbor if it is unvisited land
    logic       close;     // store the region sum
    logic       sort_step; // one compare-swap of the bubble pass
    logic       sort_rst;
    logic       emit;      // present sorted entry at the emit index
    logic       emit_inc;
    logic       clear;     // clear one grid word
    logic       job_rst;
  } cmd_t;

  typedef struct packed {
    logic scan_end;   // scan pointer past the grid
    logic scan_seed;  // scan cell is unvisited land and a slot is free
    logic queue_empty;
    logic nbr_ok;     // neighbor under test lies inside the grid
    logic sort_done;
    logic emit_last;
    logic none;       // no region found
    logic clear_end;
  } sts_t;
endpackage
`default_nettype wire

// ===== rtl/grid_island_weight_sums.sv =====
`default_nettype none
// Cells load one per cycle. After the last cell the scan reads each grid
// cell in turn; each land cell of a region is popped from the queue and its
// neighbors inside the grid are tested, and each region is closed with its
// sum. A bubble sort of the sums follows, then the results are sent one by
// one. Afterwards a pass clears every grid word with its visited bit; the
// same pass runs after reset, during which s_axis_tready stays low.
module grid_island_weight_sums #(
  parameter int unsigned MaxRows = 8,
  parameter int unsigned MaxCols = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // cell_weight[3:0], zero pad
  input  wire logic        s_axis_tlast,  // last_cell
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // region_sum[9:0], zero pad
  output logic             m_axis_tuser,  // no_land
  output logic             m_axis_tlast,  // last_result
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [3:0]  cfg_data_i
);
  logic [3:0] rows_q, cols_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 4'd8;
      cols_q <= 4'd8;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == gisum_pkg::CfgRows) rows_q <= cfg_data_i;
      if (cfg_idx_i == gisum_pkg::CfgCols) cols_q <= cfg_data_i;
    end
  end

  gisum_pkg::cmd_t cmd;
  gisum_pkg::sts_t sts;
  logic [9:0] sum;

  gisum_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(s_axis_tvalid && s_axis_tready),
    .in_last_i(s_axis_tlast),
    .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd),
    .in_ready_o(s_axis_tready), .out_valid_o(m_axis_tvalid)
  );

  gisum_dp #(.MaxRows(MaxRows), .MaxCols(MaxCols)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .weight_i(s_axis_tdata[3:0]), .rows_i(rows_q), .cols_i(cols_q),
    .sts_o(sts), .sum_o(sum), .no_land_o(m_axis_tuser), .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, sum};

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("in and out overlap");
  a_noland_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && sum == 10'd0)
    else $error("no-land word malformed");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
endmodule
`default_nettype wire

// ===== rtl/gisum_ctrl.sv =====
`default_nettype none
module gisum_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_fire_i,
  input  wire logic           in_last_i,
  input  wire logic           out_ready_i,
  input  wire gisum_pkg::sts_t sts_i,
  output gisum_pkg::cmd_t     cmd_o,
  output logic                in_ready_o,
  output logic                out_valid_o
);
  gisum_pkg::state_e state_q, state_d;
  logic [1:0] dir_q, dir_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gisum_pkg::ST_INIT;
      dir_q <= 2'd0;
    end else begin
      state_q <= state_d;
      dir_q <= dir_d;
    end
  end

  always_comb begin
    state_d = state_q;
    dir_d = dir_q;
    cmd_o = '0;
    cmd_o.dir = dir_q;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      gisum_pkg::ST_INIT: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_end) begin
          cmd_o.job_rst = 1'b1;
          state_d = gisum_pkg::ST_LOAD;
        end
      end
      gisum_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.scan_rst = 1'b1;
            state_d = gisum_pkg::ST_SCAN;
          end
        end
      end
      gisum_pkg::ST_SCAN: begin
        if (sts_i.scan_end) begin
          cmd_o.sort_rst = 1'b1;
          state_d = gisum_pkg::ST_SORT;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d = gisum_pkg::ST_SEED;
        end
      end
      gisum_pkg::ST_SEED: begin
        if (sts_i.scan_seed) begin
          cmd_o.seed = 1'b1;
          state_d = gisum_pkg::ST_POP;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d = gisum_pkg::ST_SCAN;
        end
      end
      gisum_pkg::ST_POP: begin
        if (sts_i.queue_empty) begin
          state_d = gisum_pkg::ST_DONE;
        end else begin
          cmd_o.pop = 1'b1;
          state_d = gisum_pkg::ST_TAKE;
        end
      end
      gisum_pkg::ST_TAKE: begin
        cmd_o.take = 1'b1;
        dir_d = 2'd0;
        state_d = gisum_pkg::ST_NBR;
      end
      gisum_pkg::ST_NBR: begin
        if (sts_i.nbr_ok) begin
          cmd_o.nbr_rd = 1'b1;
          state_d = gisum_pkg::ST_CHK;
        end else begin
          dir_d = dir_q + 2'd1;
          if (dir_q == 2'd3) state_d = gisum_pkg::ST_POP;
        end
      end
      gisum_pkg::ST_CHK: begin
        cmd_o.nbr = 1'b1;
        dir_d = dir_q + 2'd1;
        if (dir_q == 2'd3) state_d = gisum_pkg::ST_POP;
        else state_d = gisum_pkg::ST_NBR;
      end
      gisum_pkg::ST_DONE: begin
        cmd_o.close = 1'b1;
        cmd_o.scan_inc = 1'b1;
        state_d = gisum_pkg::ST_SCAN;
      end
      gisum_pkg::ST_SORT: begin
        if (sts_i.sort_done) begin
          state_d = gisum_pkg::ST_EMIT;
        end else begin
          cmd_o.sort_step = 1'b1;
        end
      end
      gisum_pkg::ST_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d = gisum_pkg::ST_WAIT;
      end
      gisum_pkg::ST_WAIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.emit_last || sts_i.none) begin
            state_d = gisum_pkg::ST_CLEAR;
          end else begin
            cmd_o.emit_inc = 1'b1;
            state_d = gisum_pkg::ST_EMIT;
          end
        end
      end
      gisum_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_end) begin
          cmd_o.job_rst = 1'b1;
          state_d = gisum_pkg::ST_LOAD;
        end
      end
      default: state_d = gisum_pkg::ST_INIT;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/gisum_dp.sv =====
`default_nettype none
module gisum_dp #(
  parameter int unsigned MaxRows = 8,
  parameter int unsigned MaxCols = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire gisum_pkg::cmd_t cmd_i,
  input  wire logic [3:0]      weight_i,
  input  wire logic [3:0]      rows_i,
  input  wire logic [3:0]      cols_i,
  output gisum_pkg::sts_t      sts_o,
  output logic [9:0]           sum_o,
  output logic                 no_land_o,
  output logic                 last_o
);
  localparam int unsigned CellW = gisum_pkg::CellW;
  localparam int unsigned SumW = gisum_pkg::SumW;
  localparam int unsigned QueueW = 10;

  // Grid word is {visited, weight}. Grid and queue take one write and one
  // registered read a cycle; queue entries are {row, col, weight}. The sums
  // are a small register array.
  logic [4:0]        grid_q [gisum_pkg::Cells];
  logic [QueueW-1:0] queue_q [gisum_pkg::Cells];
  logic [SumW-1:0]   sums_q [gisum_pkg::Slots];
  logic [4:0]        grid_rd_q;
  logic [QueueW-1:0] queue_rd_q;

  logic [CellW:0]   load_q, scan_q, head_q, tail_q, clr_q;
  logic [gisum_pkg::CntW-1:0] cnt_q;
  logic [SumW-1:0]  total_q;
  logic [2:0]       cr_q, cc_q, sr_q, sc_q;
  logic [3:0]       jrows_q, jcols_q;
  logic [gisum_pkg::SlotW-1:0] sidx_q, eidx_q;
  logic [gisum_pkg::SlotW:0]   spass_q;
  logic             swapped_q;
  logic [SumW-1:0]  sum_q;

  logic [3:0] rows_c, cols_c, jr, jc;
  logic [6:0] ncells, jcells;
  logic [3:0] wsat;
  always_comb begin
    rows_c = (rows_i == 4'd0) ? 4'd1 :
             (rows_i > 4'(MaxRows)) ? 4'(MaxRows) : rows_i;
    cols_c = (cols_i == 4'd0) ? 4'd1 :
             (cols_i > 4'(MaxCols)) ? 4'(MaxCols) : cols_i;
    ncells = {3'd0, rows_c} * {3'd0, cols_c};
    jr = jrows_q;
    jc = jcols_q;
    jcells = {3'd0, jr} * {3'd0, jc};
    wsat = (weight_i > 4'd9) ? 4'd9 : weight_i;
  end

  logic [CellW-1:0] scell;
  assign scell = scan_q[CellW-1:0];

  // Neighbor of the current cell.
  logic       nok;
  logic [2:0] nr, nc;
  logic [CellW-1:0] ncell;
  always_comb begin
    nr = cr_q;
    nc = cc_q;
    nok = 1'b0;
    unique case (cmd_i.dir)
      2'd0: begin nok = (cr_q != 3'd0); nr = cr_q - 3'd1; end
      2'd1: begin nok = (cc_q != 3'd0); nc = cc_q - 3'd1; end
      2'd2: begin nok = ({1'b0, cr_q} + 4'd1 < jr); nr = cr_q + 3'd1; end
      default: begin nok = ({1'b0, cc_q} + 4'd1 < jc); nc = cc_q + 3'd1; end
    endcase
    ncell = {3'd0, nr} * {2'd0, jc} + {3'd0, nc};
  end

  logic push;
  assign push = cmd_i.nbr && nok && !grid_rd_q[4] && (grid_rd_q[3:0] != 4'd0);

  // Grid write, read and queue write ports.
  logic             gwe, gre;
  logic [CellW-1:0] gwa, gra;
  logic [4:0]       gwd;
  logic              qwe;
  logic [CellW-1:0]  qwa;
  logic [QueueW-1:0] qwd;
  always_comb begin
    gwe = 1'b0;
    gwa = load_q[CellW-1:0];
    gwd = {1'b0, wsat};
    if (cmd_i.load) begin
      gwe = (load_q < ncells);
    end else if (cmd_i.clear) begin
      gwe = 1'b1;
      gwa = clr_q[CellW-1:0];
      gwd = '0;
    end else if (cmd_i.seed) begin
      gwe = 1'b1;
      gwa = scell;
      gwd = {1'b1, grid_rd_q[3:0]};
    end else if (push) begin
      gwe = 1'b1;
      gwa = ncell;
      gwd = {1'b1, grid_rd_q[3:0]};
    end
    gre = cmd_i.scan_rd || cmd_i.nbr_rd;
    gra = cmd_i.nbr_rd ? ncell : scell;
    qwe = cmd_i.seed || push;
    qwa = cmd_i.seed ? '0 : tail_q[CellW-1:0];
    qwd = cmd_i.seed ? {sr_q, sc_q, grid_rd_q[3:0]} : {nr, nc, grid_rd_q[3:0]};
  end

  always_ff @(posedge clk_i) begin
    if (gwe) grid_q[gwa] <= gwd;
    if (gre) grid_rd_q <= grid_q[gra];
    if (qwe) queue_q[qwa] <= qwd;
    if (cmd_i.pop) queue_rd_q <= queue_q[head_q[CellW-1:0]];
  end

  // Bubble pass over the sums.
  logic [SumW-1:0] sa, sb;
  logic [gisum_pkg::SlotW:0] slim;
  assign sa = sums_q[sidx_q];
  assign sb = sums_q[sidx_q + 5'd1];
  assign slim = (cnt_q == '0) ? '0 : 6'(cnt_q - 6'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0; scan_q <= '0; head_q <= '0; tail_q <= '0; clr_q <= '0;
      cnt_q <= '0; total_q <= '0; sidx_q <= '0; eidx_q <= '0;
      spass_q <= '0; swapped_q <= 1'b0; jrows_q <= 4'd8; jcols_q <= 4'd8;
      cr_q <= '0; cc_q <= '0; sr_q <= '0; sc_q <= '0; sum_q <= '0;
    end else begin
      if (cmd_i.load) begin
        if (load_q < ncells) load_q <= load_q + 7'd1;
        jrows_q <= rows_c;
        jcols_q <= cols_c;
      end
      if (cmd_i.scan_rst) begin
        scan_q <= '0;
        sr_q <= '0;
        sc_q <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.scan_inc) begin
        scan_q <= scan_q + 7'd1;
        // advance the scan coordinates, wrap at the row end
        if ({1'b0, sc_q} + 4'd1 == jc) begin
          sc_q <= '0;
          sr_q <= sr_q + 3'd1;
        end else begin
          sc_q <= sc_q + 3'd1;
        end
      end
      if (cmd_i.seed) begin
        head_q <= '0;
        tail_q <= 7'd1;
        total_q <= '0;
      end
      if (cmd_i.pop) head_q <= head_q + 7'd1;
      if (cmd_i.take) begin
        cr_q <= queue_rd_q[9:7];
        cc_q <= queue_rd_q[6:4];
        total_q <= total_q + SumW'(queue_rd_q[3:0]);
      end
      if (push) tail_q <= tail_q + 7'd1;
      if (cmd_i.close) begin
        sums_q[cnt_q[gisum_pkg::SlotW-1:0]] <= total_q;
        cnt_q <= cnt_q + 6'd1;
      end
      if (cmd_i.sort_rst) begin
        sidx_q <= '0; spass_q <= '0; swapped_q <= 1'b0; eidx_q <= '0;
      end
      if (cmd_i.sort_step) begin
        if ({1'b0, sidx_q} + 6'd1 < slim + 6'd1 && 6'(sidx_q) < slim) begin
          if (sa > sb) begin
            sums_q[sidx_q] <= sb;
            sums_q[sidx_q + 5'd1] <= sa;
            swapped_q <= 1'b1;
          end
          sidx_q <= sidx_q + 5'd1;
        end else begin
          sidx_q <= '0;
          swapped_q <= 1'b0;
          spass_q <= swapped_q ? spass_q + 6'd1 : 6'd63;
        end
      end
      if (cmd_i.emit) sum_q <= sums_q[eidx_q];
      if (cmd_i.emit_inc) eidx_q <= eidx_q + 5'd1;
      if (cmd_i.clear) clr_q <= cmd_i.job_rst ? '0 : clr_q + 7'd1;
      if (cmd_i.job_rst) load_q <= '0;
    end
  end

  always_comb begin
    sts_o.scan_end = (scan_q >= jcells);
    sts_o.scan_seed = !grid_rd_q[4] && grid_rd_q[3:0] != 4'd0 &&
                      (cnt_q < 6'(gisum_pkg::Slots));
    sts_o.queue_empty = (head_q >= tail_q);
    sts_o.nbr_ok = nok;
    sts_o.sort_done = (cnt_q < 6'd2) || (spass_q == 6'd63);
    sts_o.none = (cnt_q == '0);
    sts_o.emit_last = (6'(eidx_q) + 6'd1 >= cnt_q);
    sts_o.clear_end = (clr_q == 7'(gisum_pkg::Cells - 1));
  end

  assign sum_o = (cnt_q == '0) ? '0 : sum_q;
  assign no_land_o = (cnt_q == '0);
  assign last_o = sts_o.none || sts_o.emit_last;
endmodule
`default_nettype wire

// ===== tb/sv/tb_grid_island_weight_sums.sv =====
`timescale 1ns / 1ps
module tb_grid_island_weight_sums;

  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic [9:0] region_sum;
    logic       no_land;
    logic       last_result;
  } sum_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [3:0]  cfg_data_i;

  grid_island_weight_sums dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Predictor state
  logic [3:0] rows_reg, cols_reg;
  logic [3:0] grid_w [gisum_pkg::Cells];
  logic       seen [gisum_pkg::Cells];
  int         load_pos;
  sum_word_t  sums_pending [$];

  int errors = 0;
  int idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void clear_grid();
    for (int i = 0; i < gisum_pkg::Cells; i++) begin
      grid_w[i] = '0;
      seen[i] = 1'b0;
    end
    load_pos = 0;
  endfunction

  function automatic int fill_region(input int start, input int rows, input int cols);
    int q[$];
    int pos, r, c, n, total;
    total = 0;
    q = {q, start};
    seen[start] = 1'b1;
    while (q.size() > 0) begin
      pos = q.pop_front();
      r = pos / cols;
      c = pos % cols;
      total += grid_w[pos];
      for (int k = 0; k < 4; k++) begin
        n = -1;
        if (k == 0 && r > 0) n = pos - cols;
        if (k == 1 && c > 0) n = pos - 1;
        if (k == 2 && r + 1 < rows) n = pos + cols;
        if (k == 3 && c + 1 < cols) n = pos + 1;
        if (n >= 0 && !seen[n] && grid_w[n] != 0) begin
          seen[n] = 1'b1;
          q = {q, n};
        end
      end
    end
    return total & 10'h3ff;
  endfunction

  function automatic void predict_cell(input logic [3:0] w_in, input logic last);
    int rows, cols, total;
    logic [3:0] w;
    int found[$];
    sum_word_t s;
    rows = (rows_reg == 0) ? 1 : (rows_reg > 8 ? 8 : rows_reg);
    cols = (cols_reg == 0) ? 1 : (cols_reg > 8 ? 8 : cols_reg);
    total = rows * cols;
    w = (w_in > 9) ? 4'd9 : w_in;
    if (load_pos < total) begin
      grid_w[load_pos] = w;
      load_pos++;
    end
    if (!last) return;
    for (int i = 0; i < total; i++)
      if (!seen[i] && grid_w[i] != 0 && found.size() < gisum_pkg::Slots)
        found = {found, fill_region(i, rows, cols)};
    if (found.size() == 0) begin
      s = '{region_sum: '0, no_land: 1'b1, last_result: 1'b1};
      sums_pending = {sums_pending, s};
    end else begin
      found.sort();
      foreach (found[i]) begin
        s = '{region_sum: found[i][9:0], no_land: 1'b0,
              last_result: (i == found.size() - 1)};
        sums_pending = {sums_pending, s};
      end
    end
    clear_grid();
  endfunction

  // Sender: bursts with random gaps
  int burst_left = 0;
  task automatic send_cell(input logic [3:0] w, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, w};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_cell(w, last);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sums_pending.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [3:0] val);
    s_axis_tvalid <= 1'b0;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == gisum_pkg::CfgRows) rows_reg = val;
    else cols_reg = val;
    @(posedge clk_i);
  endtask

  task automatic set_shape(input logic [3:0] r, input logic [3:0] c);
    drain();
    write_reg(gisum_pkg::CfgRows, r);
    write_reg(gisum_pkg::CfgCols, c);
  endtask

  task automatic send_grid(input int n, input int land_pct);
    logic [3:0] w;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < land_pct) w = 4'($urandom_range(1, 15));
      else w = 4'd0;
      send_cell(w, i == n - 1);
    end
  endtask

  task automatic test_directed();
    set_shape(4'd2, 4'd2);
    send_cell(4'd0, 1'b0); send_cell(4'd0, 1'b0);
    send_cell(4'd0, 1'b0); send_cell(4'd0, 1'b1);     // all sea
    send_cell(4'd9, 1'b0); send_cell(4'd0, 1'b0);
    send_cell(4'd0, 1'b0); send_cell(4'd15, 1'b1);    // two islands, saturation
    send_cell(4'd1, 1'b0); send_cell(4'd0, 1'b1);     // short grid
    send_cell(4'd3, 1'b0); send_cell(4'd3, 1'b0); send_cell(4'd3, 1'b0);
    send_cell(4'd3, 1'b0); send_cell(4'd7, 1'b0); send_cell(4'd5, 1'b1); // extra cells
    set_shape(4'd0, 4'd15);                            // clamps to 1 x 8
    send_grid(8, 50);
    set_shape(4'd8, 4'd8);
    for (int i = 0; i < 64; i++) send_cell(((i / 8 + i % 8) % 2) ? 4'd9 : 4'd0, i == 63);
  endtask

  task automatic test_shape_change_mid_job();
    set_shape(4'd4, 4'd4);
    send_cell(4'd2, 1'b0); send_cell(4'd0, 1'b0); send_cell(4'd4, 1'b0);
    write_reg(gisum_pkg::CfgCols, 4'd2);
    send_cell(4'd6, 1'b0); send_cell(4'd1, 1'b1);
  endtask

  task automatic test_random();
    int sent;
    int n;
    logic [3:0] r, c;
    sent = 0;
    while (sent < 56) begin
      r = $urandom_range(0, 15) < 3 ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 4));
      c = $urandom_range(0, 15) < 3 ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 4));
      set_shape(r, c);
      n = ((r == 0) ? 1 : (r > 8 ? 8 : r)) * ((c == 0) ? 1 : (c > 8 ? 8 : c));
      if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n + 2);
      send_grid(n, $urandom_range(20, 80));
      sent += n;
    end
  endtask

  // Receiver stall pattern and checker
  int stall_phase = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if ((stall_phase / 64) % 3 == 0) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    sum_word_t want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        if (sums_pending.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          want = sums_pending.pop_front();
          if (m_axis_tdata[9:0] !== want.region_sum)
            report($sformatf("region_sum %0d, want %0d", m_axis_tdata[9:0], want.region_sum));
          if (m_axis_tuser !== want.no_land)
            report($sformatf("no_land %b, want %b", m_axis_tuser, want.no_land));
          if (m_axis_tlast !== want.last_result)
            report($sformatf("last_result %b, want %b", m_axis_tlast, want.last_result));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = 1'b0;
    cfg_data_i = '0;
    rows_reg = 4'd8;
    cols_reg = 4'd8;
    clear_grid();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_shape_change_mid_job();
    test_random();
    drain();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
